FILE: design/dctcp_pkg.sv
// Shared types and constants for the DCTCP alpha / reroute estimator.
// No dependencies; used by the register block, the divider and the top level.
package dctcp_pkg;

    localparam int unsigned Q_W = 17;                  // Q1.16 values
    localparam logic [Q_W-1:0] Q_ONE = 17'd65536;
    localparam int unsigned TOT_W = 32;
    localparam int unsigned SEQ_W = 31;
    localparam int unsigned CNT_W = 8;
    localparam int unsigned PADDR_W = 4;

    localparam logic [Q_W-1:0]   GAIN_RST = 17'd4096;
    localparam logic [Q_W-1:0]   THR_RST = 17'd3277;
    localparam logic [CNT_W-1:0] LIMIT_RST = 8'd1;

    typedef enum logic [1:0] {
        REG_EWMA_GAIN      = 2'd0,
        REG_REROUTE_ENABLE = 2'd1,
        REG_MARK_THRESHOLD = 2'd2,
        REG_RTT_LIMIT      = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        REQ_ACK     = 2'd0,
        REQ_RTT     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_START,
        S_DIV_WAIT,
        S_EWMA_MUL,
        S_EWMA_ADD,
        S_THR_MUL,
        S_THR_CMP,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [Q_W-1:0]   ewma_gain;
        logic             reroute_enable;
        logic [Q_W-1:0]   mark_threshold;
        logic [CNT_W-1:0] congested_rtt_limit;
    } cfg_t;

endpackage

FILE: design/dctcp_if.sv
// Valid/ready channel interfaces for the estimator: event requests in,
// estimate results out. No dependencies.
interface dctcp_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [30:0]        ack_seq;
    logic               ecn_echo;
    logic signed [31:0] prior_ack;
    logic [30:0]        max_sent_seq;
    logic [30:0]        send_next_seq;

    modport source (
        output valid, req_type, ack_seq, ecn_echo, prior_ack, max_sent_seq,
               send_next_seq,
        input  ready
    );
    modport sink (
        input  valid, req_type, ack_seq, ecn_echo, prior_ack, max_sent_seq,
               send_next_seq,
        output ready
    );
endinterface

interface dctcp_rsp_if;
    logic        valid;
    logic        ready;
    logic [16:0] alpha;
    logic        alpha_updated;
    logic        reroute;
    logic [7:0]  reroute_count;

    modport source (
        output valid, alpha, alpha_updated, reroute, reroute_count,
        input  ready
    );
    modport sink (
        input  valid, alpha, alpha_updated, reroute, reroute_count,
        output ready
    );
endinterface

FILE: design/dctcp_apb_regs.sv
// APB configuration registers of the estimator (gain, enable, threshold, limit).
// Depends on dctcp_pkg.
module dctcp_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dctcp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output dctcp_pkg::cfg_t                cfg
);
    import dctcp_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_EWMA_GAIN:      cfg_next.ewma_gain = pwdata[Q_W-1:0];
                REG_REROUTE_ENABLE: cfg_next.reroute_enable = pwdata[0];
                REG_MARK_THRESHOLD: cfg_next.mark_threshold = pwdata[Q_W-1:0];
                REG_RTT_LIMIT:      cfg_next.congested_rtt_limit = pwdata[CNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_EWMA_GAIN:      prdata = {15'd0, cfg_reg.ewma_gain};
            REG_REROUTE_ENABLE: prdata = {31'd0, cfg_reg.reroute_enable};
            REG_MARK_THRESHOLD: prdata = {15'd0, cfg_reg.mark_threshold};
            REG_RTT_LIMIT:      prdata = {24'd0, cfg_reg.congested_rtt_limit};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ewma_gain           <= GAIN_RST;
            cfg_reg.reroute_enable      <= 1'b0;
            cfg_reg.mark_threshold      <= THR_RST;
            cfg_reg.congested_rtt_limit <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/dctcp_frac_div.sv
// Radix-2 restoring divider for the marked fraction floor(num*2^16/den),
// clamped to 1.0 and zero for a zero denominator. Depends on dctcp_pkg.
module dctcp_frac_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dctcp_pkg::TOT_W-1:0]   num,
    input  logic [dctcp_pkg::TOT_W-1:0]   den,
    output logic                          done,
    output logic [dctcp_pkg::Q_W-1:0]     quot
);
    import dctcp_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [TOT_W:0]   rem_reg, rem_next;
    logic [TOT_W-1:0] den_reg, den_next;
    logic [15:0]      q_reg, q_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [TOT_W:0]   shifted;
    logic             take;

    assign shifted = {rem_reg[TOT_W-1:0], 1'b0};
    assign take    = shifted >= {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = quot_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        if (start)
        begin
            // marked >= acked means the fraction is 1.0 or more
            if (den == '0)
            begin
                quot_next = '0;
                done_next = 1'b1;
            end
            else if (num >= den)
            begin
                quot_next = Q_ONE;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 4'd15;
                rem_next  = {1'b0, num};
                den_next  = den;
            end
        end
        else if (busy_reg)
        begin
            rem_next = take ? (shifted - {1'b0, den_reg}) : shifted;
            q_next   = {q_reg[14:0], take};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quot_next = {1'b0, q_reg[14:0], take};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

endmodule

FILE: design/dctcp_alpha_and_reroute_estimator.sv
// One event beat in, one result beat out. An ACK that moves the update barrier
// passes through the 16-step divider that forms the marked fraction, then one
// multiply and one add for the EWMA; the divider returns 1.0 at once when
// every acked byte is marked. Other ACKs and timeouts, and RTT ticks with
// rerouting disabled, go straight to the result; an RTT tick with rerouting
// enabled uses the one shared 18x33 multiplier, then a compare.
// A new event is accepted as soon as the sequencer is idle, while the
// previous result may still wait in the output register.
// Depends on dctcp_pkg, dctcp_if, dctcp_apb_regs and dctcp_frac_div.
module dctcp_alpha_and_reroute_estimator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dctcp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    dctcp_req_if.sink                     req,
    dctcp_rsp_if.source                   rsp
);
    import dctcp_pkg::*;

    cfg_t cfg;

    dctcp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    seq_state_t state_reg, state_next;

    // latched event
    logic [1:0]         type_reg, type_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic               ecn_reg, ecn_next;
    logic signed [31:0] hack_reg, hack_next;
    logic [SEQ_W-1:0]   maxs_reg, maxs_next;
    logic [SEQ_W-1:0]   nexts_reg, nexts_next;

    // flow state
    logic [TOT_W-1:0] acked_reg, acked_next;
    logic [TOT_W-1:0] marked_reg, marked_next;
    logic [TOT_W-1:0] rtt_acked_reg, rtt_acked_next;
    logic [TOT_W-1:0] rtt_marked_reg, rtt_marked_next;
    logic [SEQ_W-1:0] barrier_reg, barrier_next;
    logic [Q_W-1:0]   alpha_reg, alpha_next;
    logic [CNT_W-1:0] cong_reg, cong_next;
    logic [CNT_W-1:0] reroutes_reg, reroutes_next;
    logic             updated_reg, updated_next;
    logic             rr_reg, rr_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [Q_W-1:0]   out_alpha_reg, out_alpha_next;
    logic             out_upd_reg, out_upd_next;
    logic             out_rr_reg, out_rr_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;

    // shared multiplier
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_reg, mul_next;

    logic             div_start;
    logic             div_done;
    logic [Q_W-1:0]   div_quot;

    logic signed [33:0] diff;
    logic [TOT_W-1:0]   amt;
    logic [Q_W-1:0]     gain;
    logic signed [17:0] frac_delta;
    logic signed [50:0] ewma_sum;
    logic signed [34:0] ewma_new;
    logic               congested;
    logic [CNT_W-1:0]   cong_inc;
    logic               accept;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? '1 : s[TOT_W-1:0];
    endfunction

    dctcp_frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (marked_reg),
        .den   (acked_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign div_start = (state_reg == S_DIV_START);
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.alpha         = out_alpha_reg;
    assign rsp.alpha_updated = out_upd_reg;
    assign rsp.reroute       = out_rr_reg;
    assign rsp.reroute_count = out_cnt_reg;

    // acked amount: exact difference, 1 when not positive
    assign diff = $signed({3'b000, seq_reg}) - $signed({{2{hack_reg[31]}}, hack_reg});
    assign amt  = (diff <= 34'sd0) ? 32'd1 : diff[TOT_W-1:0];

    assign gain       = cfg.ewma_gain[Q_W-1] ? Q_ONE : cfg.ewma_gain;
    assign frac_delta = $signed({1'b0, div_quot}) - $signed({1'b0, alpha_reg});

    // (1-g)*a + g*f == a*2^16 + g*(f-a)
    assign ewma_sum = $signed({18'd0, alpha_reg, 16'd0}) + mul_reg + 51'sd32768;
    assign ewma_new = ewma_sum[50:16];

    assign congested = (rtt_acked_reg != '0) &&
                       ({1'b0, rtt_marked_reg, 16'd0} > mul_reg[48:0]);
    assign cong_inc  = cong_reg + 8'd1;

    always_comb
    begin
        if (state_reg == S_THR_MUL)
        begin
            mul_a = $signed({1'b0, cfg.mark_threshold});
            mul_b = $signed({1'b0, rtt_acked_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, gain});
            mul_b = {{15{frac_delta[17]}}, frac_delta};
        end
        mul_next = 51'(mul_a * mul_b);
    end

    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        ecn_next        = ecn_reg;
        hack_next       = hack_reg;
        maxs_next       = maxs_reg;
        nexts_next      = nexts_reg;
        acked_next      = acked_reg;
        marked_next     = marked_reg;
        rtt_acked_next  = rtt_acked_reg;
        rtt_marked_next = rtt_marked_reg;
        barrier_next    = barrier_reg;
        alpha_next      = alpha_reg;
        cong_next       = cong_reg;
        reroutes_next   = reroutes_reg;
        updated_next    = updated_reg;
        rr_next         = rr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_alpha_next  = out_alpha_reg;
        out_upd_next    = out_upd_reg;
        out_rr_next     = out_rr_reg;
        out_cnt_next    = out_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next    = req.req_type;
                    seq_next     = req.ack_seq;
                    ecn_next     = req.ecn_echo;
                    hack_next    = req.prior_ack;
                    maxs_next    = req.max_sent_seq;
                    nexts_next   = req.send_next_seq;
                    updated_next = 1'b0;
                    rr_next      = 1'b0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (req_kind_t'(type_reg))
                    REQ_ACK:
                    begin
                        acked_next     = sat_add(acked_reg, amt);
                        rtt_acked_next = sat_add(rtt_acked_reg, amt);
                        if (ecn_reg)
                        begin
                            marked_next     = sat_add(marked_reg, amt);
                            rtt_marked_next = sat_add(rtt_marked_reg, amt);
                        end
                        if (seq_reg > barrier_reg)
                        begin
                            barrier_next = maxs_reg;
                            state_next   = S_DIV_START;
                        end
                    end
                    REQ_RTT:
                    begin
                        if (cfg.reroute_enable)
                        begin
                            state_next = S_THR_MUL;
                        end
                    end
                    REQ_TIMEOUT:
                    begin
                        barrier_next = nexts_reg;
                        if (cfg.reroute_enable)
                        begin
                            reroutes_next   = reroutes_reg + 8'd1;
                            rr_next         = 1'b1;
                            cong_next       = '0;
                            rtt_acked_next  = '0;
                            rtt_marked_next = '0;
                        end
                    end
                    default:
                    begin
                        // unused event code: report only
                    end
                endcase
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EWMA_MUL;
                end
            end
            S_EWMA_MUL:
            begin
                state_next = S_EWMA_ADD;
            end
            S_EWMA_ADD:
            begin
                alpha_next   = (ewma_new > 35'sd65536) ? Q_ONE : ewma_new[Q_W-1:0];
                acked_next   = '0;
                marked_next  = '0;
                updated_next = 1'b1;
                state_next   = S_DONE;
            end
            S_THR_MUL:
            begin
                state_next = S_THR_CMP;
            end
            S_THR_CMP:
            begin
                if (congested)
                begin
                    if (cong_inc >= cfg.congested_rtt_limit)
                    begin
                        reroutes_next = reroutes_reg + 8'd1;
                        rr_next       = 1'b1;
                        cong_next     = '0;
                    end
                    else
                    begin
                        cong_next = cong_inc;
                    end
                end
                else
                begin
                    cong_next = '0;
                end
                rtt_acked_next  = '0;
                rtt_marked_next = '0;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_alpha_next = alpha_reg;
                    out_upd_next   = updated_reg;
                    out_rr_next    = rr_reg;
                    out_cnt_next   = reroutes_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            acked_reg      <= '0;
            marked_reg     <= '0;
            rtt_acked_reg  <= '0;
            rtt_marked_reg <= '0;
            barrier_reg    <= '0;
            alpha_reg      <= '0;
            cong_reg       <= '0;
            reroutes_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acked_reg      <= acked_next;
            marked_reg     <= marked_next;
            rtt_acked_reg  <= rtt_acked_next;
            rtt_marked_reg <= rtt_marked_next;
            barrier_reg    <= barrier_next;
            alpha_reg      <= alpha_next;
            cong_reg       <= cong_next;
            reroutes_reg   <= reroutes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        seq_reg       <= seq_next;
        ecn_reg       <= ecn_next;
        hack_reg      <= hack_next;
        maxs_reg      <= maxs_next;
        nexts_reg     <= nexts_next;
        updated_reg   <= updated_next;
        rr_reg        <= rr_next;
        mul_reg       <= mul_next;
        out_alpha_reg <= out_alpha_next;
        out_upd_reg   <= out_upd_next;
        out_rr_reg    <= out_rr_next;
        out_cnt_reg   <= out_cnt_next;
    end

`ifndef SYNTHESIS
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_reg <= Q_ONE)
        else $error("alpha above 1.0");

    a_alpha_only_in_ewma: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EWMA_ADD) |=> $stable(alpha_reg))
        else $error("alpha changed outside the EWMA step");

    a_reroute_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(reroutes_reg) |-> (reroutes_reg == 8'($past(reroutes_reg) + 8'd1)))
        else $error("reroute count moved by other than one");

    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished while sequencer not waiting");
`endif

endmodule
